// ===== src/tedec_pkg.sv =====
// Shared types and constants for the trace event decoder.
// Field widths, register indexes, opcodes and the sequencer state type.
// No dependencies.
package tedec_pkg;

	// Field widths
	localparam int TIME_W    = 32;
	localparam int ORD_W     = 31;
	localparam int REC_W     = 32;
	localparam int DIV_W     = 16;
	localparam int COUNT_W   = 15;
	localparam int INDEX_W   = 14;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	// Default table size
	localparam int DEFAULT_TABLE_DEPTH = 16384;

	// Unwrap slack in microseconds
	localparam logic [TIME_W:0] WRAP_SLACK = 33'd1000;

	// Register reset values
	localparam logic [DIV_W-1:0]   TICKS_RESET = 16'd1;
	localparam logic [TIME_W-1:0]  WRAP_RESET  = 32'hFFFF_FFFF;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 15'd0;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TICKS_PER_US = 2'd0,
		CFG_WRAP_AMOUNT  = 2'd1,
		CFG_ENTRY_COUNT  = 2'd2
	} cfg_index_t;

	// Input opcodes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_RECORD = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_UNWRAP,
		ST_SEARCH,
		ST_DONE
	} state_t;

endpackage

// ===== src/trace_event_decoder.sv =====
// Trace event decoder top level: timestamp divide/unwrap and ordinal table search.
// Holds the ordinal table memory, a bit-serial divider and the search sequencer.
// Depends on tedec_pkg.
//
// Channel   Direction  Handshake            Carries
// in        sink       in_valid / in_stall  opcode, entry_index, entry_ordinal,
//                                           record_ordinal, record_time
// out       source     out_valid/out_stall  time_us, found, match_index, ordinal, is_exit
// cfg       sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A load word writes one table entry and gives no result. A record word runs,
// from acceptance to a loaded output register, through the one-bit-per-cycle
// restoring divider, the unwrap step, the table probes (one per cycle through
// the registered memory read, at most clog2(TABLE_DEPTH) + 1) and the output
// register load. in_stall is high for the whole record. A finished result
// waits in the output register while the next word is accepted; only the
// final load waits on out_stall. Reset clears control and the time state;
// the table is not cleared and holds nothing until loaded.
module trace_event_decoder
	import tedec_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,

	// Input word channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 opcode,
	input  logic [INDEX_W-1:0]   entry_index,
	input  logic [ORD_W-1:0]     entry_ordinal,
	input  logic [REC_W-1:0]     record_ordinal,
	input  logic [TIME_W-1:0]    record_time,

	// Result word channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [TIME_W-1:0]    time_us,
	output logic                 found,
	output logic [INDEX_W-1:0]   match_index,
	output logic [ORD_W-1:0]     ordinal,
	output logic                 is_exit,

	// Configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int STEP_W = $clog2(TIME_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TIME_W - 1);
	localparam logic [NW-1:0] DEPTH_N = NW'(TABLE_DEPTH);

	// Configuration registers
	logic [DIV_W-1:0]   ticks_q;
	logic [TIME_W-1:0]  wrap_q;
	logic [COUNT_W-1:0] count_q;

	// Sequencer
	state_t state_q, state_d;

	// Time state
	logic [TIME_W-1:0] last_q;
	logic [TIME_W-1:0] adjust_q;

	// Divider
	logic [DIV_W-1:0]  divisor_q;
	logic [DIV_W-1:0]  rem_q;
	logic [TIME_W-1:0] quot_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W:0]    div_shift;
	logic              div_fit;
	logic [DIV_W:0]    div_diff;

	// Record fields
	logic [ORD_W-1:0] key_q;
	logic             exit_q;

	// Search
	logic [CW-1:0]    lo_q, hi_q, mid_q;
	logic             found_q;
	logic [CW-1:0]    entries;
	logic [NW-1:0]    count_n;
	logic [CW-1:0]    lo_n, hi_n, mid_n;
	logic [CW:0]      mid_sum;
	logic             probe_hit;
	logic             probe_last;
	logic             wrap_hit;

	// Memory
	logic [ORD_W-1:0] mem [TABLE_DEPTH];
	logic [ORD_W-1:0] rd_q;
	logic [AW-1:0]    rd_addr;
	logic             mem_we;

	// Control
	logic in_take;
	logic rec_start;
	logic out_load;
	logic out_valid_q;

	// Output registers
	logic [TIME_W-1:0]  time_q;
	logic               found_out_q;
	logic [INDEX_W-1:0] match_q;
	logic [ORD_W-1:0]   ordinal_q;
	logic               exit_out_q;

	// Handshake decode
	assign in_take   = in_valid && !in_stall;
	assign rec_start = in_take && (opcode == OP_RECORD);
	assign mem_we    = in_take && (opcode == OP_LOAD)
	                   && (NW'(entry_index) < DEPTH_N);
	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= TICKS_RESET;
			wrap_q  <= WRAP_RESET;
			count_q <= COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TICKS_PER_US: ticks_q <= cfg_data[DIV_W-1:0];
				CFG_WRAP_AMOUNT:  wrap_q  <= cfg_data[TIME_W-1:0];
				CFG_ENTRY_COUNT:  count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the entry count to the table depth
	assign count_n = NW'(count_q);
	assign entries = (count_n > DEPTH_N) ? DEPTH_N[CW-1:0] : count_n[CW-1:0];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (rec_start) state_d = ST_DIV;
			ST_DIV:    if (step_q == LAST_STEP) state_d = ST_UNWRAP;
			ST_UNWRAP: state_d = (entries == '0) ? ST_DONE : ST_SEARCH;
			ST_SEARCH: if (probe_hit || probe_last) state_d = ST_DONE;
			ST_DONE:   if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_DONE: out_load = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Restoring divider step: one quotient bit per cycle
	assign div_shift = {rem_q, quot_q[TIME_W-1]};
	assign div_fit   = div_shift >= {1'b0, divisor_q};
	assign div_diff  = div_shift - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (rec_start) begin
			step_q <= '0;
		end else if (state_q == ST_DIV) begin
			step_q <= step_q + 1'b1;
		end
	end

	// Latch the record and run the divider
	always_ff @(posedge clk) begin
		if (rec_start) begin
			divisor_q <= (ticks_q == '0) ? TICKS_RESET : ticks_q;
			rem_q     <= '0;
			quot_q    <= record_time;
			key_q     <= record_ordinal[ORD_W-1:0];
			exit_q    <= record_ordinal[REC_W-1];
		end else if (state_q == ST_DIV) begin
			rem_q  <= div_fit ? div_diff[DIV_W-1:0] : div_shift[DIV_W-1:0];
			quot_q <= {quot_q[TIME_W-2:0], div_fit};
		end
	end

	// Wrap detection; a zero last time seeds itself and never wraps
	assign wrap_hit = (last_q != '0)
	                  && (({1'b0, quot_q} + WRAP_SLACK) < {1'b0, last_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			adjust_q <= '0;
		end else if (state_q == ST_UNWRAP) begin
			last_q <= quot_q;
			if (wrap_hit) begin
				adjust_q <= adjust_q + wrap_q;
			end
		end
	end

	// Probe compare and window narrowing
	assign probe_hit  = (rd_q == key_q);
	assign probe_last = (hi_q - lo_q) <= CW'(1);
	assign lo_n       = (key_q < rd_q) ? lo_q : mid_q;
	assign hi_n       = (key_q < rd_q) ? mid_q : hi_q;
	assign mid_sum    = {1'b0, lo_n} + {1'b0, hi_n};
	assign mid_n      = mid_sum[CW:1];

	always_ff @(posedge clk) begin
		if (state_q == ST_UNWRAP) begin
			lo_q    <= '0;
			hi_q    <= entries;
			mid_q   <= entries >> 1;
			found_q <= 1'b0;
		end else if (state_q == ST_SEARCH) begin
			if (probe_hit) begin
				found_q <= 1'b1;
			end else if (!probe_last) begin
				lo_q  <= lo_n;
				hi_q  <= hi_n;
				mid_q <= mid_n;
			end
		end
	end

	// Read address: first midpoint on unwrap, next midpoint while searching
	assign rd_addr = (state_q == ST_UNWRAP) ? AW'(entries >> 1) : AW'(mid_n);

	// Ordinal table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[AW'(entry_index)] <= entry_ordinal;
		end
		rd_q <= mem[rd_addr];
	end

	// Output register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			time_q      <= quot_q + adjust_q;
			found_out_q <= found_q;
			match_q     <= found_q ? INDEX_W'(mid_q) : '0;
			ordinal_q   <= key_q;
			exit_out_q  <= exit_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign time_us     = time_q;
	assign found       = found_out_q;
	assign match_index = match_q;
	assign ordinal     = ordinal_q;
	assign is_exit     = exit_out_q;

	// Checks
	a_rise_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result word appeared outside the finish state");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < divisor_q))
		else $error("divider remainder not below divisor");

	a_window_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (lo_q < hi_q) && (mid_q >= lo_q) && (mid_q < hi_q))
		else $error("search window out of order");

	a_miss_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found_out_q) |-> (match_q == '0))
		else $error("match index set on a miss");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q != LAST_STEP) |=> (state_q == ST_DIV))
		else $error("divider left early");

endmodule

// ===== tb/trace_event_decoder_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for trace_event_decoder: table loads, record decode and unwrap.
// Predicts each result word in-line and checks the result channel under random idle/stall.
// Depends on tedec_pkg and the trace_event_decoder RTL.
module trace_event_decoder_tb
	import tedec_pkg::*;
();

	localparam int DEPTH         = DEFAULT_TABLE_DEPTH;
	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int REPORT_LIMIT  = 10;
	localparam int BLOCK_WORDS   = 90;
	localparam int LADDER_SHIFT  = ORD_W - $clog2(DEPTH);

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam logic [ORD_W-1:0]     ORD_MAX   = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [TIME_W-1:0]  time_us;
		logic               found;
		logic [INDEX_W-1:0] match_index;
		logic [ORD_W-1:0]   ordinal;
		logic               is_exit;
	} decoded_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 opcode;
	logic [INDEX_W-1:0]   entry_index;
	logic [ORD_W-1:0]     entry_ordinal;
	logic [REC_W-1:0]     record_ordinal;
	logic [TIME_W-1:0]    record_time;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [TIME_W-1:0]    time_us;
	logic                 found;
	logic [INDEX_W-1:0]   match_index;
	logic [ORD_W-1:0]     ordinal;
	logic                 is_exit;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	// Predictor state: register shadows, table image and time unwrap state
	logic [DIV_W-1:0]   div_ticks;
	logic [TIME_W-1:0]  wrap_us;
	logic [COUNT_W-1:0] entry_count;
	logic [ORD_W-1:0]   ord_table [DEPTH];
	bit                 loaded [DEPTH];
	int unsigned        loaded_len;
	logic [TIME_W-1:0]  last_us;
	logic [TIME_W-1:0]  adjust_us;
	logic [TIME_W-1:0]  raw_ticks;

	decoded_t    pending_results [$];
	int          idle_pct;
	int          stall_pct;
	int unsigned cycle_count;
	int unsigned mismatches;
	int unsigned loads_sent;
	int unsigned records_sent;
	int unsigned hits_seen;
	int unsigned wraps_seen;

	trace_event_decoder u_top (.*);

	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Random backpressure on the result channel
	always @(negedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	// Compare each accepted result word with the oldest prediction
	always @(posedge clk) begin : check_results
		decoded_t want;
		decoded_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.time_us     = time_us;
			got.found       = found;
			got.match_index = match_index;
			got.ordinal     = ordinal;
			got.is_exit     = is_exit;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected result word time %h found %b index %0d ord %h exit %b",
						$realtime, got.time_us, got.found, got.match_index, got.ordinal,
						got.is_exit);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display({"%0t: mismatch (exp/act) time %h/%h found %b/%b ",
							"index %0d/%0d ord %h/%h exit %b/%b"}, $realtime,
							want.time_us, got.time_us, want.found, got.found,
							want.match_index, got.match_index, want.ordinal, got.ordinal,
							want.is_exit, got.is_exit);
				end
			end
		end
	end

	// Binary search with midpoint probing; slot stays 0 on a miss
	function automatic bit lookup_ordinal(input logic [ORD_W-1:0] key,
		output logic [INDEX_W-1:0] slot);
		int unsigned n;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		bit hit;
		bit done;
		n = entry_count;
		if (n > DEPTH)
			n = DEPTH;
		slot = '0;
		hit = 1'b0;
		done = (n == 0);
		lo = 0;
		hi = n;
		mid = (lo + hi) / 2;
		while (!done) begin
			if (ord_table[mid] == key) begin
				slot = mid[INDEX_W-1:0];
				hit = 1'b1;
				done = 1'b1;
			end else if (hi - lo <= 1) begin
				done = 1'b1;
			end else begin
				if (key < ord_table[mid])
					hi = mid;
				else
					lo = mid;
				mid = (lo + hi) / 2;
			end
		end
		return hit;
	endfunction

	// Divide, unwrap and look up one record; advances the time state
	function automatic decoded_t decode_record(input logic [REC_W-1:0] rord,
		input logic [TIME_W-1:0] rtime);
		decoded_t res;
		logic [TIME_W-1:0] divisor;
		logic [TIME_W-1:0] quot;
		logic [INDEX_W-1:0] slot;
		divisor = (div_ticks == 0) ? TIME_W'(1) : TIME_W'(div_ticks);
		quot = rtime / divisor;
		if (last_us == 0)
			last_us = quot;
		if ({1'b0, quot} + WRAP_SLACK < {1'b0, last_us}) begin
			adjust_us = adjust_us + wrap_us;
			wraps_seen++;
		end
		last_us = quot;
		res.found = lookup_ordinal(rord[ORD_W-1:0], slot);
		res.time_us = quot + adjust_us;
		res.match_index = slot;
		res.ordinal = rord[ORD_W-1:0];
		res.is_exit = rord[REC_W-1];
		records_sent++;
		if (res.found)
			hits_seen++;
		return res;
	endfunction

	function automatic void store_entry(input logic [INDEX_W-1:0] idx,
		input logic [ORD_W-1:0] value);
		ord_table[idx] = value;
		loaded[idx] = 1'b1;
		while (loaded_len < DEPTH && loaded[loaded_len])
			loaded_len++;
		loads_sent++;
	endfunction

	// Send one input word, idling first at random, and predict on acceptance
	task automatic send_word(input logic op, input logic [INDEX_W-1:0] idx,
		input logic [ORD_W-1:0] eord, input logic [REC_W-1:0] rord,
		input logic [TIME_W-1:0] rtime);
		@(negedge clk);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		opcode = op;
		entry_index = idx;
		entry_ordinal = eord;
		record_ordinal = rord;
		record_time = rtime;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (op == OP_LOAD)
			store_entry(idx, eord);
		else
			pending_results.push_back(decode_record(rord, rtime));
	endtask

	task automatic load_entry(input logic [INDEX_W-1:0] idx, input logic [ORD_W-1:0] value);
		send_word(OP_LOAD, idx, value, REC_W'($urandom), TIME_W'($urandom));
	endtask

	task automatic post_record(input logic [REC_W-1:0] rord, input logic [TIME_W-1:0] rtime);
		send_word(OP_RECORD, INDEX_W'($urandom), ORD_W'($urandom), rord, rtime);
	endtask

	// Drop valid, wait out all results, then let the last word finish
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register; unused upper bits of the tick and count data carry noise
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
		logic [CFG_DAT_W-1:0] data;
		data = value;
		if (idx == CFG_TICKS_PER_US)
			data[CFG_DAT_W-1:DIV_W] = $urandom;
		else if (idx == CFG_ENTRY_COUNT)
			data[CFG_DAT_W-1:COUNT_W] = $urandom;
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_TICKS_PER_US: div_ticks = data[DIV_W-1:0];
			CFG_WRAP_AMOUNT:  wrap_us = data;
			CFG_ENTRY_COUNT:  entry_count = data[COUNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_config(input logic [DIV_W-1:0] ticks, input logic [TIME_W-1:0] wrap,
		input logic [COUNT_W-1:0] count);
		wait_idle();
		cfg_write(CFG_TICKS_PER_US, CFG_DAT_W'(ticks));
		cfg_write(CFG_WRAP_AMOUNT, wrap);
		cfg_write(CFG_ENTRY_COUNT, CFG_DAT_W'(count));
	endtask

	function automatic logic [DIV_W-1:0] pick_ticks();
		case ($urandom_range(4))
			0: return '0;
			1: return DIV_W'(1);
			2: return '1;
			3: return DIV_W'($urandom_range(50, 2));
			default: return DIV_W'($urandom);
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] pick_wrap();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			2: return $urandom_range(5000, 1);
			default: return $urandom;
		endcase
	endfunction

	// Never search past the written prefix of the table
	function automatic logic [COUNT_W-1:0] pick_count();
		logic [COUNT_W-1:0] count;
		case ($urandom_range(6))
			0: count = '0;
			1: count = COUNT_W'(1);
			2: count = COUNT_W'(2);
			3: count = COUNT_W'($urandom_range(64, 3));
			4: count = COUNT_W'(DEPTH);
			5: count = '1;
			default: count = COUNT_W'($urandom_range(DEPTH, 0));
		endcase
		if (count > loaded_len)
			count = COUNT_W'(loaded_len);
		return count;
	endfunction

	// Half the keys come from the searched range; the rest land next to entries, at the ends or anywhere
	function automatic logic [REC_W-1:0] pick_record_ordinal();
		int unsigned n;
		logic [ORD_W-1:0] key;
		n = (entry_count > DEPTH) ? DEPTH : entry_count;
		key = (n == 0) ? ORD_W'($urandom) : ord_table[$urandom_range(n - 1)];
		case ($urandom_range(9))
			0, 1, 2, 3, 4: ;
			5, 6: key = $urandom_range(1) ? key + 1'b1 : key - 1'b1;
			7: key = $urandom_range(1) ? ORD_MAX : '0;
			default: key = ORD_W'($urandom);
		endcase
		return {1'($urandom_range(1)), key};
	endfunction

	// Raw counter mostly runs forward; sometimes steps back near the slack or wraps
	function automatic logic [TIME_W-1:0] next_raw_time();
		int unsigned per_us;
		int unsigned roll;
		per_us = (div_ticks == 0) ? 1 : div_ticks;
		roll = $urandom_range(99);
		if (roll < 70)
			raw_ticks = raw_ticks + $urandom_range(2000) * per_us;
		else if (roll < 80)
			raw_ticks = raw_ticks - $urandom_range(1100) * per_us;
		else if (roll < 90)
			raw_ticks = $urandom_range(raw_ticks);
		else if (roll < 95)
			raw_ticks = '0;
		else
			raw_ticks = $urandom;
		return raw_ticks;
	endfunction

	// Keep the table mostly sorted by loading between the neighbors
	function automatic logic [ORD_W-1:0] pick_entry_value(input int unsigned idx);
		logic [ORD_W-1:0] lower;
		logic [ORD_W-1:0] upper;
		lower = (idx > 0) ? ord_table[idx - 1] : '0;
		upper = (idx < DEPTH - 1) ? ord_table[idx + 1] : ORD_MAX;
		if ($urandom_range(9) < 8 && lower <= upper)
			return ORD_W'($urandom_range(upper, lower));
		return ORD_W'($urandom);
	endfunction

	// Strictly rising with the slot, so probes compare the way slot numbers do
	function automatic logic [ORD_W-1:0] ladder_value(input int unsigned idx);
		return (idx == DEPTH - 1) ? ORD_MAX : ORD_W'(idx << LADDER_SHIFT);
	endfunction

	// Reset values, seeding, exact slack boundary, wrap, small last time
	task automatic test_reset_defaults();
		post_record(32'h0000_0000, 32'd5000);
		post_record(32'h8000_0005, 32'd4000);
		post_record(32'hFFFF_FFFF, 32'd2999);
		post_record(32'h7FFF_FFFF, 32'hFFFF_FFFF);
		post_record(REC_W'($urandom), 32'd0);
		post_record(REC_W'($urandom), 32'd500);
		post_record(REC_W'($urandom), 32'd0);
	endtask

	// Short table: ends, duplicates, misses, one and two entries, divisor extremes
	task automatic test_small_table();
		logic [ORD_W-1:0] vals [8];
		vals = '{31'd0, 31'd10, 31'd20, 31'd20, 31'd35, 31'd100, 31'd1000, ORD_MAX};
		for (int i = 0; i < 8; i++)
			load_entry(INDEX_W'(i), vals[i]);
		set_config('0, '0, COUNT_W'(8));
		cfg_write(CFG_SPARE, $urandom);
		post_record(32'h0000_0000, 32'd700);
		post_record(32'hFFFF_FFFF, 32'd0);
		post_record(32'h0000_0014, TIME_W'($urandom));
		post_record(32'h8000_0015, TIME_W'($urandom));
		post_record(32'h0000_03E8, TIME_W'($urandom));
		set_config('1, 32'h0000_1234, COUNT_W'(1));
		post_record(32'h8000_0000, 32'hFFFF_FFFF);
		post_record(32'h0000_0005, 32'd0);
		set_config(DIV_W'(3), '1, COUNT_W'(2));
		post_record(32'h0000_000A, TIME_W'($urandom));
		post_record(32'h0000_0009, TIME_W'($urandom));
	endtask

	// Search the full and oversized counts; load only the slots each search probes
	task automatic test_full_table();
		int unsigned target;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		bit done;
		idle_pct = 0;
		stall_pct = 0;
		for (int pass = 0; pass < 2; pass++) begin
			set_config(DIV_W'(1), '1, (pass == 0) ? COUNT_W'(DEPTH) : '1);
			for (int k = 0; k < 6; k++) begin
				target = (k == 0) ? 0 : (k == 1) ? DEPTH - 1 : $urandom_range(DEPTH - 1);
				lo = 0;
				hi = DEPTH;
				done = 1'b0;
				// walk the probe path toward the target slot
				while (!done) begin
					mid = (lo + hi) / 2;
					load_entry(INDEX_W'(mid), ladder_value(mid));
					if (mid == target || hi - lo <= 1)
						done = 1'b1;
					else if (target < mid)
						hi = mid;
					else
						lo = mid;
				end
				post_record({1'($urandom_range(1)), ladder_value(target)}, next_raw_time());
			end
		end
	endtask

	// Random traffic in blocks, each under a fresh register setting
	task automatic test_random_traffic(input int idle, input int stall);
		int unsigned idx;
		idle_pct = idle;
		stall_pct = stall;
		for (int blk = 0; blk < 4; blk++) begin
			set_config(pick_ticks(), pick_wrap(), pick_count());
			for (int i = 0; i < BLOCK_WORDS; i++) begin
				// now and then, hold off until all results have drained
				if ($urandom_range(99) == 0)
					wait_idle();
				if ($urandom_range(99) < 25) begin
					idx = $urandom_range(1) ? $urandom_range(63) : $urandom_range(DEPTH - 1);
					load_entry(INDEX_W'(idx), pick_entry_value(idx));
				end else begin
					post_record(pick_record_ordinal(), next_raw_time());
				end
			end
		end
	endtask

	initial begin
		in_valid = 1'b0;
		opcode = OP_LOAD;
		entry_index = '0;
		entry_ordinal = '0;
		record_ordinal = '0;
		record_time = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TICKS_PER_US;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		loads_sent = 0;
		records_sent = 0;
		hits_seen = 0;
		wraps_seen = 0;
		div_ticks = TICKS_RESET;
		wrap_us = WRAP_RESET;
		entry_count = COUNT_RESET;
		loaded_len = 0;
		last_us = '0;
		adjust_us = '0;
		raw_ticks = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_small_table();
		test_full_table();
		test_random_traffic(0, 0);
		test_random_traffic(63, 0);
		test_random_traffic(0, 63);
		test_random_traffic(25, 25);
		wait_idle();

		$display("Ran %0d table loads and %0d records: %0d ordinals matched, %0d wraps unwrapped.",
			loads_sent, records_sent, hits_seen, wraps_seen);
		$display("Mixes: free-running, sender idle, result stall, both; %0d mismatches.",
			mismatches);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
src/tedec_pkg.sv
src/trace_event_decoder.sv
tb/trace_event_decoder_tb.sv
